// ----- rtl/sce_pkg.sv -----
// shared types, codes and helpers of the string comparator engine
`default_nettype none
package sce_pkg;

  // input action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TEXT  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // comparator codes
  localparam logic [1:0] CMP_OCTET   = 2'd0;
  localparam logic [1:0] CMP_CASEMAP = 2'd1;
  localparam logic [1:0] CMP_NUMERIC = 2'd2;

  // relation codes
  localparam logic [2:0] REL_EQ = 3'd0;
  localparam logic [2:0] REL_NE = 3'd1;
  localparam logic [2:0] REL_GT = 3'd2;
  localparam logic [2:0] REL_GE = 3'd3;
  localparam logic [2:0] REL_LT = 3'd4;
  localparam logic [2:0] REL_LE = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_COMPARATOR = 2'd0;
  localparam logic [1:0] CFG_MATCH_MODE = 2'd1;
  localparam logic [1:0] CFG_RELATION   = 2'd2;
  localparam logic [1:0] CFG_PAT_LENGTH = 2'd3;

  // signed order codes
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_LT = 2'b11;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LZ   = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  localparam logic [6:0] COUNT_SAT = 7'd127;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_TEXT,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  value;
    logic [5:0]  index;
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic casemap);
    if (casemap && c >= CHAR_LA && c <= CHAR_LZ) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic [1:0] sign_of(input logic gt, input logic lt);
    if (gt) begin
      return ORD_GT;
    end
    if (lt) begin
      return ORD_LT;
    end
    return ORD_EQ;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sce_front.sv -----
// front end: decodes input transfers into commands and drops unused actions
`default_nettype none
module sce_front (
  input  wire logic          s_valid_i,
  input  wire logic [15:0]   s_data_i,
  input  wire logic          q_ready_i,
  output sce_pkg::cmd_t      cmd_o,
  output logic               push_o,
  output logic               s_ready_o
);
  import sce_pkg::*;

  logic [1:0] action;
  logic       keep;

  assign action = s_data_i[1:0];

  // classify the action field
  always_comb begin
    cmd_o.value = s_data_i[9:2];
    cmd_o.index = s_data_i[15:10];
    keep        = 1'b1;
    unique case (action)
      ACT_WRITE: cmd_o.kind = CMD_WRITE;
      ACT_TEXT:  cmd_o.kind = CMD_TEXT;
      ACT_END:   cmd_o.kind = CMD_END;
      default: begin
        cmd_o.kind = CMD_TEXT;
        keep       = 1'b0;
      end
    endcase
  end

  // unused actions are taken and discarded
  assign s_ready_o = q_ready_i;
  assign push_o    = s_valid_i && q_ready_i && keep;

endmodule
`default_nettype wire

// ----- rtl/sce_queue.sv -----
// two-entry command queue between front and back
`default_nettype none
module sce_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sce_pkg::cmd_t push_cmd_i,
  output logic               ready_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output sce_pkg::cmd_t      cmd_o
);
  import sce_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rptr_q];

  // pointer and count update
  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sce_back.sv -----
// back end: pattern store, per-byte compare, substring search and result register
`default_nettype none
module sce_back #(
  parameter int PatternMax = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [6:0]    cfg_data_i,
  input  wire logic          q_valid_i,
  input  wire sce_pkg::cmd_t q_cmd_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output logic               verdict_o,
  output logic [1:0]         order_o
);
  import sce_pkg::*;

  localparam int IW = $clog2(PatternMax);
  localparam int LW = $clog2(PatternMax + 1);
  localparam int CW = (LW > 8) ? LW : 8;
  localparam logic [CW-1:0] PM_W = CW'(PatternMax);

  // configuration registers
  logic [1:0] cmp_q;
  logic       mode_q;
  logic [2:0] rel_q;
  logic [6:0] plen_q;

  // pattern store and text state
  logic [7:0]            pat_q [PatternMax];
  logic [6:0]            tc_q, tc_d;
  logic [1:0]            fd_q, fd_d;
  logic [PatternMax-1:0] pm_q, pm_d;
  logic                  hit_q, hit_d;
  logic                  run_q, run_d;
  logic                  seen_q, seen_d;
  logic [6:0]            sig_q, sig_d;
  logic [1:0]            nd_q, nd_d;
  logic                  led_q, led_d;

  // result register
  logic       ovalid_q;
  logic       verdict_q, verdict_d;
  logic [1:0] order_q, order_d;

  logic                  casemap;
  logic [CW-1:0]         n;
  logic [7:0]            c, fc;
  logic [PatternMax-1:0] eq, gt, in_n;
  logic [CW-1:0]         run_len, zeros, s_len, ti, idx_w;
  logic                  found_nd, found_nz;
  logic [CW:0]           zi;
  logic [7:0]            nref;
  logic                  prun;
  logic [1:0]            ord;
  logic                  do_text, do_end, do_write, out_free;

  assign casemap = (cmp_q == CMP_CASEMAP);
  assign n  = (CW'(plen_q) > PM_W) ? PM_W : CW'(plen_q);
  assign c  = q_cmd_i.value;
  assign fc = fold(c, casemap);
  assign ti = CW'(tc_q);

  // per-lane compares against every pattern byte
  always_comb begin
    for (int k = 0; k < PatternMax; k++) begin
      eq[k]   = (fc == fold(pat_q[k], casemap));
      gt[k]   = (fc > fold(pat_q[k], casemap));
      in_n[k] = (CW'(k) < n);
    end
  end

  // leading digit run of the pattern
  always_comb begin
    run_len  = PM_W;
    zeros    = PM_W;
    found_nd = 1'b0;
    found_nz = 1'b0;
    for (int k = 0; k < PatternMax; k++) begin
      if (!found_nd && !(in_n[k] && is_digit(pat_q[k]))) begin
        run_len  = CW'(k);
        found_nd = 1'b1;
      end
      if (!found_nz && !(in_n[k] && pat_q[k] == CHAR_ZERO)) begin
        zeros    = CW'(k);
        found_nz = 1'b1;
      end
    end
    s_len = run_len - zeros;
  end

  assign prun = (n != '0) && is_digit(pat_q[0]);
  assign zi   = {1'b0, zeros} + (CW + 1)'(sig_q);
  assign nref = pat_q[zi[IW-1:0]];

  // handshake with queue and result register
  assign out_free = !ovalid_q || res_ready_i;
  assign pop_o    = q_valid_i && ((q_cmd_i.kind != CMD_END) || out_free);
  assign do_write = pop_o && (q_cmd_i.kind == CMD_WRITE);
  assign do_text  = pop_o && (q_cmd_i.kind == CMD_TEXT);
  assign do_end   = pop_o && (q_cmd_i.kind == CMD_END);
  assign idx_w    = CW'(q_cmd_i.index);

  // text byte update, and clear of the text state on end of text
  always_comb begin
    tc_d   = tc_q;
    fd_d   = fd_q;
    pm_d   = pm_q;
    hit_d  = hit_q;
    run_d  = run_q;
    seen_d = seen_q;
    sig_d  = sig_q;
    nd_d   = nd_q;
    led_d  = led_q;
    if (do_text) begin
      // first differing byte
      if (fd_q == ORD_EQ && ti < n) begin
        fd_d = sign_of(gt[ti[IW-1:0]], !eq[ti[IW-1:0]] && !gt[ti[IW-1:0]]);
      end
      // shift-and over active lanes
      for (int k = 0; k < PatternMax; k++) begin
        if (in_n[k]) begin
          if (k == 0) begin
            pm_d[k] = eq[k];
          end else begin
            pm_d[k] = pm_q[k-1] && eq[k];
          end
        end
      end
      if (n != '0 && pm_d[IW'(n - CW'(1))]) begin
        hit_d = 1'b1;
      end
      // leading numeric run
      if (run_q && is_digit(c)) begin
        if (tc_q == '0) begin
          led_d = 1'b1;
        end
        if (seen_q || c != CHAR_ZERO) begin
          seen_d = 1'b1;
          if (nd_q == ORD_EQ && CW'(sig_q) < s_len && zi < (CW + 1)'(PatternMax)) begin
            nd_d = sign_of(c > nref, c < nref);
          end
          if (sig_q != COUNT_SAT) begin
            sig_d = sig_q + 7'd1;
          end
        end
      end else begin
        run_d = 1'b0;
      end
      if (tc_q != COUNT_SAT) begin
        tc_d = tc_q + 7'd1;
      end
    end else if (do_end) begin
      tc_d   = '0;
      fd_d   = ORD_EQ;
      pm_d   = '0;
      hit_d  = 1'b0;
      run_d  = 1'b1;
      seen_d = 1'b0;
      sig_d  = '0;
      nd_d   = ORD_EQ;
      led_d  = 1'b0;
    end
  end

  // final order and verdict
  always_comb begin
    if (cmp_q == CMP_NUMERIC) begin
      priority if (prun && led_q) begin
        if (CW'(sig_q) != s_len) begin
          ord = sign_of(CW'(sig_q) > s_len, CW'(sig_q) < s_len);
        end else begin
          ord = nd_q;
        end
      end else if (prun) begin
        ord = ORD_GT;
      end else if (led_q) begin
        ord = ORD_LT;
      end else begin
        ord = ORD_EQ;
      end
    end else if (fd_q != ORD_EQ) begin
      ord = fd_q;
    end else begin
      ord = sign_of(ti > n, ti < n);
    end
    if (mode_q && cmp_q != CMP_NUMERIC) begin
      verdict_d = hit_q || (n == '0);
      order_d   = ORD_EQ;
    end else begin
      order_d = ord;
      unique case (rel_q)
        REL_EQ:  verdict_d = (ord == ORD_EQ);
        REL_NE:  verdict_d = (ord != ORD_EQ);
        REL_GT:  verdict_d = (ord == ORD_GT);
        REL_GE:  verdict_d = (ord != ORD_LT);
        REL_LT:  verdict_d = (ord == ORD_LT);
        REL_LE:  verdict_d = (ord != ORD_GT);
        default: verdict_d = 1'b0;
      endcase
    end
  end

  // control and text state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q    <= CMP_OCTET;
      mode_q   <= 1'b0;
      rel_q    <= REL_EQ;
      plen_q   <= '0;
      tc_q     <= '0;
      fd_q     <= ORD_EQ;
      pm_q     <= '0;
      hit_q    <= 1'b0;
      run_q    <= 1'b1;
      seen_q   <= 1'b0;
      sig_q    <= '0;
      nd_q     <= ORD_EQ;
      led_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COMPARATOR: cmp_q  <= cfg_data_i[1:0];
          CFG_MATCH_MODE: mode_q <= cfg_data_i[0];
          CFG_RELATION:   rel_q  <= cfg_data_i[2:0];
          CFG_PAT_LENGTH: plen_q <= cfg_data_i;
          default: ;
        endcase
      end
      tc_q   <= tc_d;
      fd_q   <= fd_d;
      pm_q   <= pm_d;
      hit_q  <= hit_d;
      run_q  <= run_d;
      seen_q <= seen_d;
      sig_q  <= sig_d;
      nd_q   <= nd_d;
      led_q  <= led_d;
      if (do_end) begin
        ovalid_q <= 1'b1;
      end else if (res_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // pattern store and result payload
  always_ff @(posedge clk_i) begin
    if (do_write && idx_w < PM_W) begin
      pat_q[idx_w[IW-1:0]] <= c;
    end
    if (do_end) begin
      verdict_q <= verdict_d;
      order_q   <= order_d;
    end
  end

  assign res_valid_o = ovalid_q;
  assign verdict_o   = verdict_q;
  assign order_o     = order_q;

`ifndef SYNTHESIS
  a_end_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_end |=> ovalid_q) else $error("end of text did not load a result");
  a_end_clears_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_end |=> (tc_q == '0 && sig_q == '0 && pm_q == '0))
    else $error("text state not cleared after end of text");
  a_sig_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sig_q <= tc_q) else $error("significant digits exceed text length");
  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> order_q != 2'b10) else $error("invalid order code");
  a_no_pop_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !res_ready_i) |-> !do_end) else $error("result overwritten");
`endif

endmodule
`default_nettype wire

// ----- rtl/string_comparator_engine_top.sv -----
// top level of the string comparator engine
`default_nettype none
// Compares a stored pattern against a streamed text, octet, ascii casemap or
// ascii numeric, in relational or substring mode. Each input transfer carries
// a pattern write, a text byte or an end of text; only end of text produces a
// result transfer. One item is taken per cycle: the front decoder feeds a
// two-entry queue and the back end handles each item as it pops it,
// comparing the byte against all pattern lanes in parallel. A result passes
// through the queue and then the result register after its end of text
// transfer; it comes later only while an earlier result still waits. The
// pace drops only while the result register waits on m_axis_tready_i. No
// clearing pass follows reset.
module string_comparator_engine_top #(
  parameter int PatternMax = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // action[1:0], byte_value[9:2], pattern_index[15:10]
  input  wire logic [15:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // verdict[0], order[2:1], zero fill [7:3]
  output logic [7:0]       m_axis_tdata_o
);
  import sce_pkg::*;

  cmd_t       push_cmd, q_cmd;
  logic       push, q_ready, q_valid, pop;
  logic       verdict;
  logic [1:0] order;

  sce_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_data_i  (s_axis_tdata_i),
    .q_ready_i (q_ready),
    .cmd_o     (push_cmd),
    .push_o    (push),
    .s_ready_o (s_axis_tready_o)
  );

  sce_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  sce_back #(
    .PatternMax (PatternMax)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .verdict_o   (verdict),
    .order_o     (order)
  );

  assign m_axis_tdata_o = {5'd0, order, verdict};

endmodule
`default_nettype wire
